// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared codes and control types for the stable minimum priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Operation codes carried on the input tuser
  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Result status codes carried on the output tuser
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // Per-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic push_en;   // insert the broadcast entry (queue not full)
    logic pop_en;    // shift every entry one cell toward the head (queue not empty)
    logic clear_en;  // drop all entries
  } cell_ctrl_t;

endpackage

// ===== sv/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted shift-register queue: holds one entry, keeps,
// loads the new entry, or takes a neighbor's entry each cycle.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int COST_BITS    = 16,
  parameter int PAYLOAD_BITS = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  spq_pkg::cell_ctrl_t     ctrl_i,
  input  logic [COST_BITS-1:0]    new_cost_i,
  input  logic [PAYLOAD_BITS-1:0] new_id_i,
  // neighbor toward the head
  input  logic                    prev_keep_i,
  input  logic                    prev_valid_i,
  input  logic [COST_BITS-1:0]    prev_cost_i,
  input  logic [PAYLOAD_BITS-1:0] prev_id_i,
  // neighbor toward the tail
  input  logic                    next_valid_i,
  input  logic [COST_BITS-1:0]    next_cost_i,
  input  logic [PAYLOAD_BITS-1:0] next_id_i,
  // own state
  output logic                    keep_o,
  output logic                    valid_o,
  output logic [COST_BITS-1:0]    cost_o,
  output logic [PAYLOAD_BITS-1:0] id_o,
  // next state, used for the head report
  output logic                    valid_d_o,
  output logic [COST_BITS-1:0]    cost_d_o,
  output logic [PAYLOAD_BITS-1:0] id_d_o
);

  logic                    valid_q, valid_d;
  logic [COST_BITS-1:0]    cost_q, cost_d;
  logic [PAYLOAD_BITS-1:0] id_q, id_d;

  // entry stays put on a push when it is not behind the new cost
  assign keep_o = valid_q && (cost_q <= new_cost_i);

  // next-state select
  always_comb begin
    valid_d = valid_q;
    cost_d  = cost_q;
    id_d    = id_q;
    if (ctrl_i.clear_en) begin
      valid_d = 1'b0;
    end else if (ctrl_i.push_en) begin
      if (keep_o) begin
        valid_d = valid_q;
      end else if (prev_keep_i) begin
        valid_d = 1'b1;
        cost_d  = new_cost_i;
        id_d    = new_id_i;
      end else begin
        valid_d = prev_valid_i;
        cost_d  = prev_cost_i;
        id_d    = prev_id_i;
      end
    end else if (ctrl_i.pop_en) begin
      valid_d = next_valid_i;
      cost_d  = next_cost_i;
      id_d    = next_id_i;
    end
  end

  // valid flag under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // entry payload, no reset
  always_ff @(posedge clk_i) begin
    cost_q <= cost_d;
    id_q   <= id_d;
  end

  assign valid_o   = valid_q;
  assign cost_o    = cost_q;
  assign id_o      = id_q;
  assign valid_d_o = valid_d;
  assign cost_d_o  = cost_d;
  assign id_d_o    = id_d;

endmodule

// ===== sv/stable_min_priority_queue.sv =====
// A result word is registered and is valid in the cycle after its input word is accepted.
// Throughput: one word per cycle while the output is not stalled; push, pop and clear
// each act through one compare per cell and one neighbor shift across the row.
// Input is taken while a result waits, as long as the output register frees.
// Reset: valid flags, entry count and output valid clear at once; entry
// contents are not reset and are read only after being written.
// ----------------------------------------------------------------------------
// stable_min_priority_queue
// Bounded min-priority queue, FIFO among equal costs, built as a row of
// sorted shift-register cells with a registered result word.
// ----------------------------------------------------------------------------
module stable_min_priority_queue #(
  parameter int CAPACITY     = 64,
  parameter int COST_BITS    = 16,
  parameter int PAYLOAD_BITS = 24,
  localparam int CntBits  = $clog2(CAPACITY + 1),
  localparam int InRaw    = COST_BITS + PAYLOAD_BITS,
  localparam int InW      = ((InRaw + 7) / 8) * 8,
  localparam int OutRaw   = 2 * PAYLOAD_BITS + 2 * COST_BITS + 1 + CntBits,
  localparam int OutW     = ((OutRaw + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [InW-1:0]  s_axis_tdata,  // cost, payload
  input  logic [1:0]      s_axis_tuser,  // kind
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OutW-1:0] m_axis_tdata,  // popped_payload, popped_cost, head_valid,
                                         // head_payload, head_cost, occupancy
  output logic [1:0]      m_axis_tuser   // status
);

  localparam logic [CntBits-1:0] Cap = CntBits'(CAPACITY);

  // input word fields
  logic [COST_BITS-1:0]    in_cost;
  logic [PAYLOAD_BITS-1:0] in_id;
  logic [1:0]              in_kind;
  logic                    in_accept;

  assign in_cost   = s_axis_tdata[COST_BITS-1:0];
  assign in_id     = s_axis_tdata[COST_BITS +: PAYLOAD_BITS];
  assign in_kind   = s_axis_tuser;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // occupancy
  logic [CntBits-1:0] count_q, count_d;
  logic               full, empty;

  assign full  = (count_q == Cap);
  assign empty = (count_q == '0);

  // command decode
  spq_pkg::cell_ctrl_t ctrl;
  always_comb begin
    ctrl = '0;
    if (in_accept) begin
      unique case (in_kind)
        spq_pkg::KIND_PUSH:  ctrl.push_en  = !full;
        spq_pkg::KIND_POP:   ctrl.pop_en   = !empty;
        spq_pkg::KIND_CLEAR: ctrl.clear_en = 1'b1;
        default:             ctrl = '0;
      endcase
    end
  end

  always_comb begin
    priority if (ctrl.clear_en) begin
      count_d = '0;
    end else if (ctrl.push_en) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.pop_en) begin
      count_d = count_q - 1'b1;
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // cell row
  logic                    cell_keep  [CAPACITY];
  logic                    cell_valid [CAPACITY];
  logic [COST_BITS-1:0]    cell_cost  [CAPACITY];
  logic [PAYLOAD_BITS-1:0] cell_id    [CAPACITY];
  logic                    head_valid_d;
  logic [COST_BITS-1:0]    head_cost_d;
  logic [PAYLOAD_BITS-1:0] head_id_d;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    prev_keep, prev_valid, next_valid;
    logic [COST_BITS-1:0]    prev_cost, next_cost;
    logic [PAYLOAD_BITS-1:0] prev_id, next_id;

    if (i == 0) begin : g_first
      // head cell: nothing ahead, new entry lands here unless it keeps
      assign prev_keep  = 1'b1;
      assign prev_valid = 1'b0;
      assign prev_cost  = '0;
      assign prev_id    = '0;
    end else begin : g_mid_prev
      assign prev_keep  = cell_keep[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_cost  = cell_cost[i-1];
      assign prev_id    = cell_id[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_cost  = '0;
      assign next_id    = '0;
    end else begin : g_mid_next
      assign next_valid = cell_valid[i+1];
      assign next_cost  = cell_cost[i+1];
      assign next_id    = cell_id[i+1];
    end

    if (i == 0) begin : g_head
      spq_cell #(
        .COST_BITS    (COST_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (ctrl),
        .new_cost_i   (in_cost),
        .new_id_i     (in_id),
        .prev_keep_i  (prev_keep),
        .prev_valid_i (prev_valid),
        .prev_cost_i  (prev_cost),
        .prev_id_i    (prev_id),
        .next_valid_i (next_valid),
        .next_cost_i  (next_cost),
        .next_id_i    (next_id),
        .keep_o       (cell_keep[i]),
        .valid_o      (cell_valid[i]),
        .cost_o       (cell_cost[i]),
        .id_o         (cell_id[i]),
        .valid_d_o    (head_valid_d),
        .cost_d_o     (head_cost_d),
        .id_d_o       (head_id_d)
      );
    end else begin : g_body
      spq_cell #(
        .COST_BITS    (COST_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (ctrl),
        .new_cost_i   (in_cost),
        .new_id_i     (in_id),
        .prev_keep_i  (prev_keep),
        .prev_valid_i (prev_valid),
        .prev_cost_i  (prev_cost),
        .prev_id_i    (prev_id),
        .next_valid_i (next_valid),
        .next_cost_i  (next_cost),
        .next_id_i    (next_id),
        .keep_o       (cell_keep[i]),
        .valid_o      (cell_valid[i]),
        .cost_o       (cell_cost[i]),
        .id_o         (cell_id[i]),
        .valid_d_o    (),
        .cost_d_o     (),
        .id_d_o       ()
      );
    end
  end

  // result word
  logic [1:0]              status_d;
  logic [COST_BITS-1:0]    pop_cost_d;
  logic [PAYLOAD_BITS-1:0] pop_id_d;
  logic [OutRaw-1:0]       res_raw;

  always_comb begin
    status_d = spq_pkg::STATUS_OK;
    if (in_kind == spq_pkg::KIND_PUSH && full) begin
      status_d = spq_pkg::STATUS_FULL;
    end else if (in_kind == spq_pkg::KIND_POP && empty) begin
      status_d = spq_pkg::STATUS_EMPTY;
    end
  end

  assign pop_cost_d = ctrl.pop_en ? cell_cost[0] : '0;
  assign pop_id_d   = ctrl.pop_en ? cell_id[0]   : '0;
  assign res_raw = {count_d,
                    head_valid_d ? head_cost_d : {COST_BITS{1'b0}},
                    head_valid_d ? head_id_d   : {PAYLOAD_BITS{1'b0}},
                    head_valid_d,
                    pop_cost_d,
                    pop_id_d};

  logic            out_valid_q;
  logic [OutW-1:0] out_data_q;
  logic [1:0]      out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= OutW'(res_raw);
      out_user_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Cap)
    else $error("entry count above capacity");

  a_head_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid[0] == (count_q != '0))
    else $error("head valid flag disagrees with entry count");

  a_full_push_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_kind == spq_pkg::KIND_PUSH && full) |=> count_q == $past(count_q))
    else $error("rejected push changed the entry count");

  a_tail_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid[CAPACITY-1] == full)
    else $error("last cell valid disagrees with full flag");

endmodule

// ===== test/spq_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spq_result_checker
// Watches both stream channels of the priority queue. It keeps its own sorted
// copy of the queue, predicts the result word of every accepted operation and
// compares each returned word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module spq_result_checker #(
  parameter int CAPACITY     = 64,
  parameter int COST_BITS    = 16,
  parameter int PAYLOAD_BITS = 24,
  parameter int CNT_BITS     = 7,
  parameter int IN_W         = 40,
  parameter int OUT_W        = 88
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [IN_W-1:0]  in_data_i,    // cost, payload
  input  logic [1:0]       in_kind_i,    // kind
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [OUT_W-1:0] out_data_i,   // popped_payload, popped_cost, head_valid,
                                         // head_payload, head_cost, occupancy
  input  logic [1:0]       out_status_i, // status
  output int               err_cnt_o,
  output int               pending_o
);

  // One result word, unpacked
  typedef struct packed {
    logic [1:0]              status;
    logic [PAYLOAD_BITS-1:0] pop_id;
    logic [COST_BITS-1:0]    pop_cost;
    logic                    head_valid;
    logic [PAYLOAD_BITS-1:0] head_id;
    logic [COST_BITS-1:0]    head_cost;
    logic [CNT_BITS-1:0]     occupancy;
  } queue_result_t;

  // Sorted copy of the queue: slot 0 is the head
  logic [COST_BITS-1:0]    slot_cost [CAPACITY];
  logic [PAYLOAD_BITS-1:0] slot_id   [CAPACITY];
  int                      slot_count;

  queue_result_t predicted_results[$];

  // Apply one operation to the queue copy and return the result it gives
  function automatic queue_result_t apply_queue_op(input logic [1:0] kind,
                                                   input logic [COST_BITS-1:0] cost,
                                                   input logic [PAYLOAD_BITS-1:0] id);
    queue_result_t res;
    int            pos;
    int            i;
    res = '0;
    res.status = spq_pkg::STATUS_OK;
    case (kind)
      spq_pkg::KIND_PUSH: begin
        if (slot_count >= CAPACITY) begin
          res.status = spq_pkg::STATUS_FULL;
        end else begin
          // insert behind every entry of equal or lower cost
          pos = 0;
          while (pos < slot_count && slot_cost[pos] <= cost) pos++;
          for (i = slot_count; i > pos; i--) begin
            slot_cost[i] = slot_cost[i-1];
            slot_id[i]   = slot_id[i-1];
          end
          slot_cost[pos] = cost;
          slot_id[pos]   = id;
          slot_count++;
        end
      end
      spq_pkg::KIND_POP: begin
        if (slot_count == 0) begin
          res.status = spq_pkg::STATUS_EMPTY;
        end else begin
          res.pop_cost = slot_cost[0];
          res.pop_id   = slot_id[0];
          for (i = 0; i + 1 < slot_count; i++) begin
            slot_cost[i] = slot_cost[i+1];
            slot_id[i]   = slot_id[i+1];
          end
          slot_count--;
        end
      end
      spq_pkg::KIND_CLEAR: begin
        slot_count = 0;
      end
      default: ;  // unused kind leaves the queue alone
    endcase
    if (slot_count > 0) begin
      res.head_valid = 1'b1;
      res.head_id    = slot_id[0];
      res.head_cost  = slot_cost[0];
    end
    res.occupancy = slot_count[CNT_BITS-1:0];
    return res;
  endfunction

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      err_cnt_o++;
    end
  endtask

  // Output side is checked before the input side: a word returned at this edge
  // always belongs to an operation taken at an earlier edge
  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t want;
    queue_result_t got;
    if (!rst_ni) begin
      slot_count = 0;
      err_cnt_o  = 0;
      predicted_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.status     = out_status_i;
        got.pop_id     = out_data_i[23:0];
        got.pop_cost   = out_data_i[39:24];
        got.head_valid = out_data_i[40];
        got.head_id    = out_data_i[64:41];
        got.head_cost  = out_data_i[80:65];
        got.occupancy  = out_data_i[87:81];
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual 0x%0h status %0d",
                   $time, out_data_i, out_status_i);
          err_cnt_o++;
        end else begin
          want = predicted_results.pop_front();
          report_field("status", 32'(want.status), 32'(got.status));
          report_field("popped_payload", 32'(want.pop_id), 32'(got.pop_id));
          report_field("popped_cost", 32'(want.pop_cost), 32'(got.pop_cost));
          report_field("head_valid", 32'(want.head_valid), 32'(got.head_valid));
          report_field("head_payload", 32'(want.head_id), 32'(got.head_id));
          report_field("head_cost", 32'(want.head_cost), 32'(got.head_cost));
          report_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
        end
      end
      if (in_valid_i && in_ready_i) begin
        predicted_results.push_back(apply_queue_op(in_kind_i, in_data_i[15:0],
                                                   in_data_i[39:16]));
      end
    end
    pending_o = predicted_results.size();
  end

endmodule

// ===== test/stable_min_priority_queue_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stable_min_priority_queue_test
// Drives push, pop, clear and unused operations into the priority queue in
// random bursts while the result side stalls on its own pattern. A directed
// opening covers empty, equal-cost ordering and extreme values; random phases
// then fill and drain the queue and mix operations at varying push rates.
// ----------------------------------------------------------------------------
module stable_min_priority_queue_test;

  localparam int CAPACITY     = 64;
  localparam int IN_W         = 40;
  localparam int OUT_W        = 88;
  localparam int RANDOM_ITEMS = 1900;
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 4;

  // kind 3 carries no operation
  localparam logic [1:0] KIND_NOP = 2'd3;

  // receiver stall modes
  localparam logic [1:0] RX_OPEN     = 2'd0;
  localparam logic [1:0] RX_COIN     = 2'd1;
  localparam logic [1:0] RX_SLOW     = 2'd2;
  localparam logic [1:0] RX_PERIODIC = 2'd3;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic [1:0]       s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [1:0]       m_axis_tuser;

  int          err_cnt;
  int          pending_cnt;
  int          cycle_cnt = 0;
  int          burst_left = 0;
  logic [1:0]  ready_mode = RX_OPEN;
  logic [7:0]  rx_phase = '0;

  stable_min_priority_queue u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  spq_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_kind_i    (s_axis_tuser),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .out_status_i (m_axis_tuser),
    .err_cnt_o    (err_cnt),
    .pending_o    (pending_cnt)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: stall mode is picked anew whenever the 8-bit phase counter wraps
  always @(posedge clk_i) begin
    rx_phase <= rx_phase + 8'd1;
    if (rx_phase == 8'd0) ready_mode <= 2'($urandom_range(0, 3));
    case (ready_mode)
      RX_OPEN:     m_axis_tready <= 1'b1;
      RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
      RX_SLOW:     m_axis_tready <= ($urandom_range(0, 3) == 0);
      RX_PERIODIC: m_axis_tready <= (rx_phase[2:0] < 3'd5);
      default:     m_axis_tready <= 1'b1;
    endcase
  end

  // mostly tiny costs so that ties are common, plus extremes and full range
  function automatic logic [15:0] pick_cost();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 10) return 16'($urandom_range(0, 7));
    if (sel == 10) return 16'h0000;
    if (sel == 11) return 16'hFFFF;
    if (sel == 12) return 16'h8000;
    if (sel == 13) return 16'h7FFF;
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  // one word on the input channel, with a random gap between bursts
  task automatic send_op(input logic [1:0] kind, input logic [15:0] cost,
                         input logic [23:0] id);
    logic taken;
    int   gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {id, cost};
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic push_random();
    send_op(spq_pkg::KIND_PUSH, pick_cost(), 24'($urandom_range(0, 24'hFFFFFF)));
  endtask

  task automatic pop_head();
    send_op(spq_pkg::KIND_POP, 16'($urandom), 24'($urandom));
  endtask

  // stimulus
  initial begin
    int left;
    int n;
    int len;
    int push_pct;
    int r;
    rst_ni        = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= spq_pkg::KIND_PUSH;
    s_axis_tdata  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty queue, ties served in arrival order, extremes
    send_op(spq_pkg::KIND_POP,   16'h0000, 24'h000000);
    send_op(KIND_NOP,            16'hFFFF, 24'hFFFFFF);
    send_op(spq_pkg::KIND_CLEAR, 16'h1234, 24'h123456);
    send_op(spq_pkg::KIND_PUSH,  16'h0005, 24'h000001);
    send_op(spq_pkg::KIND_PUSH,  16'h0005, 24'h000002);
    send_op(spq_pkg::KIND_PUSH,  16'h0005, 24'h000003);
    send_op(spq_pkg::KIND_PUSH,  16'hFFFF, 24'hFFFFFF);
    send_op(spq_pkg::KIND_PUSH,  16'h0000, 24'h000000);
    send_op(spq_pkg::KIND_PUSH,  16'h0004, 24'hABCDEF);
    send_op(KIND_NOP,            16'h0000, 24'h000000);
    repeat (7) pop_head();
    send_op(spq_pkg::KIND_PUSH,  16'hFFFF, 24'h800000);
    send_op(spq_pkg::KIND_PUSH,  16'h8000, 24'h7FFFFF);
    send_op(spq_pkg::KIND_CLEAR, 16'h0000, 24'h000000);
    send_op(spq_pkg::KIND_POP,   16'hFFFF, 24'hFFFFFF);

    // random phases
    left = RANDOM_ITEMS;
    while (left > 0) begin
      if ($urandom_range(0, 4) == 0) begin
        // fill past full, then drain past empty
        n = $urandom_range(CAPACITY + 1, CAPACITY + 4);
        repeat (n) push_random();
        repeat (n) pop_head();
        left -= 2 * n;
      end else begin
        case ($urandom_range(0, 3))
          0:       push_pct = 15;
          1:       push_pct = 50;
          2:       push_pct = 70;
          default: push_pct = 90;
        endcase
        len = $urandom_range(20, 100);
        repeat (len) begin
          r = $urandom_range(0, 99);
          if (r == 0) send_op(spq_pkg::KIND_CLEAR, 16'($urandom), 24'($urandom));
          else if (r == 1) send_op(KIND_NOP, 16'($urandom), 24'($urandom));
          else if (r < push_pct + 2) push_random();
          else pop_head();
        end
        left -= len;
      end
    end
    s_axis_tvalid <= 1'b0;

    // wait for every predicted word, then a short drain
    do @(negedge clk_i); while (pending_cnt != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/spq_pkg.sv
sv/spq_cell.sv
sv/stable_min_priority_queue.sv
test/spq_result_checker.sv
test/stable_min_priority_queue_test.sv
